/* hdl/bc7_pkg.sv */
// Shared types, mode tables and partition/anchor/weight tables for the BC7 decoder.
// Depends on nothing; every other file refers into it by scoped names.
package bc7_pkg;

  // One compressed block as received on the input channel
  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  // One decoded texel as sent on the output channel
  typedef struct packed {
    logic [3:0] texel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       invalid_block;
    logic       last_texel;
  } out_word_t;

  // Block after header and endpoint decode, passed from front to back
  typedef struct packed {
    logic                  invalid;
    logic [2:0]            mode;
    logic [5:0]            part;
    logic [1:0]            rot;
    logic                  isel;
    logic [3:0][5:0][7:0]  ep;    // [channel][endpoint], expanded to 8 bits
    logic [63:0]           idx0;  // primary index stream, lsb first
    logic [47:0]           idx1;  // secondary index stream (modes 4 and 5)
  } dec_t;

  // Per-mode layout
  localparam int unsigned M_SUB  [8] = '{3, 2, 3, 2, 1, 1, 1, 2};
  localparam int unsigned M_PART [8] = '{4, 6, 6, 6, 0, 0, 0, 6};
  localparam int unsigned M_ROT  [8] = '{0, 0, 0, 0, 2, 2, 0, 0};
  localparam int unsigned M_ISEL [8] = '{0, 0, 0, 0, 1, 0, 0, 0};
  localparam int unsigned M_CB   [8] = '{4, 6, 5, 7, 5, 7, 7, 5};
  localparam int unsigned M_AB   [8] = '{0, 0, 0, 0, 6, 8, 7, 5};
  localparam int unsigned M_UPB  [8] = '{1, 0, 0, 1, 0, 0, 1, 1};
  localparam int unsigned M_SPB  [8] = '{0, 1, 0, 0, 0, 0, 0, 0};
  localparam logic [2:0]  M_IB0  [8] = '{3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd2};
  localparam logic [2:0]  M_IB1  [8] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd3, 3'd2, 3'd0, 3'd0};
  localparam logic [1:0]  M_NSUB [8] = '{2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2};

  localparam logic [15:0] PART2 [64] = '{
    16'hcccc, 16'h8888, 16'heeee, 16'hecc8, 16'hc880, 16'hfeec, 16'hfec8, 16'hec80,
    16'hc800, 16'hffec, 16'hfe80, 16'he800, 16'hffe8, 16'hff00, 16'hfff0, 16'hf000,
    16'hf710, 16'h008e, 16'h7100, 16'h08ce, 16'h008c, 16'h7310, 16'h3100, 16'h8cce,
    16'h088c, 16'h3110, 16'h6666, 16'h366c, 16'h17e8, 16'h0ff0, 16'h718e, 16'h399c,
    16'haaaa, 16'hf0f0, 16'h5a5a, 16'h33cc, 16'h3c3c, 16'h55aa, 16'h9696, 16'ha55a,
    16'h73ce, 16'h13c8, 16'h324c, 16'h3bdc, 16'h6996, 16'hc33c, 16'h9966, 16'h0660,
    16'h0272, 16'h04e4, 16'h4e40, 16'h2720, 16'hc936, 16'h936c, 16'h39c6, 16'h639c,
    16'h9336, 16'h9cc6, 16'h817e, 16'he718, 16'hccf0, 16'h0fcc, 16'h7744, 16'hee22
  };

  localparam logic [31:0] PART3 [64] = '{
    32'haa685050, 32'h6a5a5040, 32'h5a5a4200, 32'h5450a0a8,
    32'ha5a50000, 32'ha0a05050, 32'h5555a0a0, 32'h5a5a5050,
    32'haa550000, 32'haa555500, 32'haaaa5500, 32'h90909090,
    32'h94949494, 32'ha4a4a4a4, 32'ha9a59450, 32'h2a0a4250,
    32'ha5945040, 32'h0a425054, 32'ha5a5a500, 32'h55a0a0a0,
    32'ha8a85454, 32'h6a6a4040, 32'ha4a45000, 32'h1a1a0500,
    32'h0050a4a4, 32'haaa59090, 32'h14696914, 32'h69691400,
    32'ha08585a0, 32'haa821414, 32'h50a4a450, 32'h6a5a0200,
    32'ha9a58000, 32'h5090a0a8, 32'ha8a09050, 32'h24242424,
    32'h00aa5500, 32'h24924924, 32'h24499224, 32'h50a50a50,
    32'h500aa550, 32'haaaa4444, 32'h66660000, 32'ha5a0a5a0,
    32'h50a050a0, 32'h69286928, 32'h44aaaa44, 32'h66666600,
    32'haa444444, 32'h54a854a8, 32'h95809580, 32'h96969600,
    32'ha85454a8, 32'h80959580, 32'haa141414, 32'h96960000,
    32'haaaa1414, 32'ha05050a0, 32'ha0a5a5a0, 32'h96000000,
    32'h40804080, 32'ha9a8a9a8, 32'haaaaaa44, 32'h2a4a5254
  };

  localparam logic [3:0] ANCHOR2 [64] = '{
    15, 15, 15, 15, 15, 15, 15, 15, 15, 15, 15, 15, 15, 15, 15, 15,
    15,  2,  8,  2,  2,  8,  8, 15,  2,  8,  2,  2,  8,  8,  2,  2,
    15, 15,  6,  8,  2,  8, 15, 15,  2,  8,  2,  2,  2, 15, 15,  6,
     6,  2,  6,  8, 15, 15,  2,  2, 15, 15, 15, 15, 15,  2,  2, 15
  };

  localparam logic [3:0] ANCHOR3A [64] = '{
     3,  3, 15, 15,  8,  3, 15, 15,  8,  8,  6,  6,  6,  5,  3,  3,
     3,  3,  8, 15,  3,  3,  6, 10,  5,  8,  8,  6,  8,  5, 15, 15,
     8, 15,  3,  5,  6, 10,  8, 15, 15,  3, 15,  5, 15, 15, 15, 15,
     3, 15,  5,  5,  5,  8,  5, 10,  5, 10,  8, 13, 15, 12,  3,  3
  };

  localparam logic [3:0] ANCHOR3B [64] = '{
    15,  8,  8,  3, 15, 15,  3,  8, 15, 15, 15, 15, 15, 15, 15,  8,
    15,  8, 15,  3, 15,  8, 15,  8,  3, 15,  6, 10, 15, 15, 10,  8,
    15,  3, 15, 10, 10,  8,  9, 10,  6, 15,  8, 15,  3,  6,  6,  8,
    15,  3, 15, 15, 15, 15, 15, 15, 15, 15, 15, 15,  3, 15, 15,  8
  };

  localparam logic [6:0] WT2 [4]  = '{0, 21, 43, 64};
  localparam logic [6:0] WT3 [8]  = '{0, 9, 18, 27, 37, 46, 55, 64};
  localparam logic [6:0] WT4 [16] = '{0, 4, 9, 13, 17, 21, 26, 30,
                                      34, 38, 43, 47, 51, 55, 60, 64};

  // Interpolation weight for an index of the given bit count
  function automatic logic [6:0] weight(input logic [2:0] bits, input logic [3:0] idx);
    logic [6:0] w;
    if (bits == 3'd2) w = WT2[idx[1:0]];
    else if (bits == 3'd3) w = WT3[idx[2:0]];
    else w = WT4[idx];
    return w;
  endfunction

endpackage

/* hdl/bc7_queue.sv */
// Two-entry queue of decoded blocks between front and back.
// Depends on bc7_pkg for the decoded block type.
module bc7_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bc7_pkg::dec_t push_data,
  output logic          full,
  input  logic          pop,
  output bc7_pkg::dec_t pop_data,
  output logic          empty
);

  bc7_pkg::dec_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/bc7_front.sv */
// Front end: registers an incoming block, finds its mode and unpacks header,
// endpoints, p-bits and index streams into a decoded word. Depends on bc7_pkg.
module bc7_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bc7_pkg::in_word_t in_word,
  output logic              push,
  output bc7_pkg::dec_t     push_data,
  input  logic              q_full
);

  // bits [pos +: n] of the block, n up to 8
  function automatic logic [7:0] getb(input logic [127:0] b, input int pos, input int n);
    logic [127:0] s;
    s = b >> pos;
    return s[7:0] & 8'((9'd1 << n) - 9'd1);
  endfunction

  // full unpack for one fixed mode
  function automatic bc7_pkg::dec_t unpack(input logic [127:0] blk, input int m);
    bc7_pkg::dec_t d;
    int            pos, nb, pb, nsub, n, off0, off1;
    logic [7:0]    raw [4][6];
    logic [7:0]    tt;
    logic          pa, pbb;
    d    = '0;
    nsub = int'(bc7_pkg::M_SUB[m]);
    pb   = int'(bc7_pkg::M_UPB[m] + bc7_pkg::M_SPB[m]);
    pos  = m + 1;
    d.mode = 3'(m);
    d.part = 6'(getb(blk, pos, int'(bc7_pkg::M_PART[m])));
    pos    = pos + int'(bc7_pkg::M_PART[m]);
    d.rot  = 2'(getb(blk, pos, int'(bc7_pkg::M_ROT[m])));
    pos    = pos + int'(bc7_pkg::M_ROT[m]);
    tt     = getb(blk, pos, int'(bc7_pkg::M_ISEL[m]));
    d.isel = tt[0];
    pos    = pos + int'(bc7_pkg::M_ISEL[m]);
    // raw endpoints, colour channels then alpha
    for (int c = 0; c < 4; c++) begin
      nb = (c < 3) ? int'(bc7_pkg::M_CB[m]) : int'(bc7_pkg::M_AB[m]);
      for (int e = 0; e < 6; e++) begin
        raw[c][e] = 8'h00;
        if (nb != 0 && e < 2 * nsub) begin
          raw[c][e] = 8'(getb(blk, pos, nb) << pb);
          pos = pos + nb;
        end
      end
    end
    // p-bits, unique per endpoint or shared per subset
    for (int s = 0; s < 3; s++) begin
      if (pb != 0 && s < nsub) begin
        tt  = getb(blk, pos, 1);
        pa  = tt[0];
        pos = pos + 1;
        pbb = pa;
        if (bc7_pkg::M_SPB[m] == 0) begin
          tt  = getb(blk, pos, 1);
          pbb = tt[0];
          pos = pos + 1;
        end
        for (int c = 0; c < 4; c++) begin
          raw[c][2*s]   = raw[c][2*s]   | {7'd0, pa};
          raw[c][2*s+1] = raw[c][2*s+1] | {7'd0, pbb};
        end
      end
    end
    // expand to 8 bits by bit replication
    for (int c = 0; c < 4; c++) begin
      nb = (c < 3) ? int'(bc7_pkg::M_CB[m]) : int'(bc7_pkg::M_AB[m]);
      for (int e = 0; e < 6; e++) begin
        n = nb + pb;
        if (nb == 0 || e >= 2 * nsub) begin
          d.ep[c][e] = 8'hff;
        end else if (n >= 8) begin
          d.ep[c][e] = raw[c][e];
        end else begin
          tt = 8'(raw[c][e] << (8 - n));
          d.ep[c][e] = tt | (tt >> n);
        end
      end
    end
    off0   = pos;
    off1   = pos + 16 * int'(bc7_pkg::M_IB0[m]) - 1;
    d.idx0 = 64'(blk >> off0);
    d.idx1 = 48'(blk >> off1);
    return d;
  endfunction

  logic [127:0]  blk_r, blk_nxt;
  logic          full_r, full_nxt;
  logic          take;
  logic [2:0]    mode;
  logic          found;
  bc7_pkg::dec_t cand [8];

  // input holding register
  assign in_stall = full_r && q_full;
  assign take     = in_valid && !in_stall;
  assign push     = full_r && !q_full;

  always_comb begin
    full_nxt = take ? 1'b1 : (push ? 1'b0 : full_r);
    blk_nxt  = take ? {in_word.block_high, in_word.block_low} : blk_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  // mode is the position of the lowest set bit
  always_comb begin
    mode  = 3'd0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (blk_r[i]) begin
        mode  = 3'(i);
        found = 1'b1;
      end
    end
  end

  // one unpacker per mode, then select
  for (genvar gm = 0; gm < 8; gm++) begin : g_mode
    assign cand[gm] = unpack(blk_r, gm);
  end

  always_comb begin
    push_data         = cand[mode];
    push_data.invalid = !found;
  end

endmodule

/* hdl/bc7_back.sv */
// Back end: walks the 16 texels of a decoded block, picks subset, index and
// weights, then interpolates and rotates into the output register. Depends on bc7_pkg.
module bc7_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  bc7_pkg::dec_t      q_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output bc7_pkg::out_word_t out_word
);

  function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [6:0] w);
    logic [14:0] s, aw, bw;
    aw = {7'd0, a} * {8'd0, 7'd64 - w};
    bw = {7'd0, b} * {8'd0, w};
    s  = aw + bw + 15'd32;
    return s[13:6];
  endfunction

  bc7_pkg::dec_t cur_r, cur_nxt;
  logic [63:0]   idx0_r, idx0_nxt;
  logic [47:0]   idx1_r, idx1_nxt;
  logic [3:0]    t_r, t_nxt;
  logic          busy_r, busy_nxt;
  logic          en, emit, load;

  // texel selection signals
  logic [1:0] sub, p3;
  logic [3:0] anc;
  logic       is_anc;
  logic [2:0] ib0, ib1, n0, n1;
  logic [3:0] i0, i1;
  logic [6:0] wc, wa;

  // stage A registers
  logic                  a_valid_r;
  logic [3:0]            a_t_r;
  logic [6:0]            a_wc_r, a_wa_r;
  logic [3:0][7:0]       a_e0_r, a_e1_r;
  logic [1:0]            a_rot_r;
  logic                  a_inv_r;

  bc7_pkg::out_word_t out_r, out_nxt;
  logic               out_valid_r;
  logic [7:0]         r, g, b, a;

  // pipeline moves whenever the output slot can take a word
  assign en   = !(out_valid_r && out_stall);
  assign emit = busy_r && en;
  assign load = !q_empty && (!busy_r || (emit && t_r == 4'd15));
  assign pop  = load;

  // block sequencer
  always_comb begin
    cur_nxt  = cur_r;
    idx0_nxt = idx0_r;
    idx1_nxt = idx1_r;
    t_nxt    = t_r;
    busy_nxt = busy_r;
    if (emit) begin
      idx0_nxt = idx0_r >> n0;
      idx1_nxt = idx1_r >> n1;
      t_nxt    = t_r + 4'd1;
      if (t_r == 4'd15) busy_nxt = 1'b0;
    end
    if (load) begin
      cur_nxt  = q_data;
      idx0_nxt = q_data.idx0;
      idx1_nxt = q_data.idx1;
      t_nxt    = 4'd0;
      busy_nxt = 1'b1;
    end
  end

  // subset, anchor, index and weights of the current texel
  always_comb begin
    sub = 2'd0;
    anc = 4'd0;
    p3  = bc7_pkg::PART3[cur_r.part][{t_r, 1'b0} +: 2];
    if (bc7_pkg::M_NSUB[cur_r.mode] == 2'd2) begin
      sub = {1'b0, bc7_pkg::PART2[cur_r.part][t_r]};
      anc = sub[0] ? bc7_pkg::ANCHOR2[cur_r.part] : 4'd0;
    end else if (bc7_pkg::M_NSUB[cur_r.mode] == 2'd3) begin
      sub = (p3 == 2'd3) ? 2'd2 : p3;
      if (sub == 2'd1) anc = bc7_pkg::ANCHOR3A[cur_r.part];
      else if (sub == 2'd2) anc = bc7_pkg::ANCHOR3B[cur_r.part];
    end
    is_anc = (t_r == anc);
    ib0    = bc7_pkg::M_IB0[cur_r.mode];
    ib1    = bc7_pkg::M_IB1[cur_r.mode];
    n0     = ib0 - {2'd0, is_anc};
    n1     = (ib1 != 3'd0) ? ib1 - {2'd0, is_anc} : 3'd0;
    i0     = idx0_r[3:0] & 4'((5'd1 << n0) - 5'd1);
    i1     = (ib1 != 3'd0) ? (idx1_r[3:0] & 4'((5'd1 << n1) - 5'd1)) : i0;
    if (cur_r.isel && ib1 != 3'd0) begin
      wc = bc7_pkg::weight(ib1, i1);
      wa = bc7_pkg::weight(ib0, i0);
    end else begin
      wc = bc7_pkg::weight(ib0, i0);
      wa = bc7_pkg::weight((ib1 != 3'd0) ? ib1 : ib0, i1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (en) begin
        a_valid_r   <= emit;
        out_valid_r <= a_valid_r;
      end
    end
  end

  // sequencer payload and stage A
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    idx0_r <= idx0_nxt;
    idx1_r <= idx1_nxt;
    t_r    <= t_nxt;
    if (en) begin
      a_t_r   <= t_r;
      a_wc_r  <= wc;
      a_wa_r  <= wa;
      a_rot_r <= cur_r.rot;
      a_inv_r <= cur_r.invalid;
      for (int c = 0; c < 4; c++) begin
        a_e0_r[c] <= cur_r.ep[c][{sub, 1'b0}];
        a_e1_r[c] <= cur_r.ep[c][{sub, 1'b1}];
      end
    end
  end

  // interpolate, rotate, zero on invalid blocks
  always_comb begin
    r = lerp(a_e0_r[0], a_e1_r[0], a_wc_r);
    g = lerp(a_e0_r[1], a_e1_r[1], a_wc_r);
    b = lerp(a_e0_r[2], a_e1_r[2], a_wc_r);
    a = lerp(a_e0_r[3], a_e1_r[3], a_wa_r);
    out_nxt.texel_index   = a_t_r;
    out_nxt.last_texel    = (a_t_r == 4'd15);
    out_nxt.invalid_block = a_inv_r;
    out_nxt.red   = r;
    out_nxt.green = g;
    out_nxt.blue  = b;
    out_nxt.alpha = a;
    unique case (a_rot_r)
      2'd1: begin out_nxt.red = a;   out_nxt.alpha = r; end
      2'd2: begin out_nxt.green = a; out_nxt.alpha = g; end
      2'd3: begin out_nxt.blue = a;  out_nxt.alpha = b; end
      default: ;
    endcase
    if (a_inv_r) begin
      out_nxt.red   = 8'd0;
      out_nxt.green = 8'd0;
      out_nxt.blue  = 8'd0;
      out_nxt.alpha = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

/* hdl/bc7_block_decoder.sv */
// Top level of the BC7 block decoder: front unpacker, block queue, texel back end.
// Depends on bc7_pkg, bc7_front, bc7_queue and bc7_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_word) takes one 128-bit compressed
//   block per word, low and high halves in one struct.
//   Output channel (out_valid / out_stall / out_word) gives the 16 texels of each
//   block in raster order, one word per texel, last_texel set on texel 15.
//   Blocks with no mode bit give zero texels with invalid_block set.
// Path: a taken block passes the front input register, queue, texel sequencer,
//   weight stage and output reg before its first texel shows on out_word.
// Throughput: one texel per cycle while out_stall is low and blocks are queued;
//   the texel sequencer in the back end sets that rate. The front takes the next blocks
//   while texels are still going out, up to the queue depth of two plus one.
// Reset: synchronous, active low; clears all valid and busy state, drops any
//   block in flight.
// Stall: when out_stall is high while out_valid is high the output word holds and the back end
//   freezes; the queue then fills and in_stall rises.
module bc7_block_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bc7_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bc7_pkg::out_word_t out_word
);

  logic          push, pop, q_full, q_empty;
  bc7_pkg::dec_t push_data, pop_data;

  bc7_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  bc7_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  bc7_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
